>>> sv/mmcs_pkg.sv
package mmcs_pkg;

	// Width of the sample field on the input stream, whatever the active bits
	localparam int unsigned SAMPLE_FIELD_W = 16;

	// Gray output: width, and one quotient bit resolved per divider step
	localparam int unsigned GRAY_BITS = 8;
	localparam int unsigned STEP_W    = $clog2(GRAY_BITS);

	// Entries in the queue between the front and back parts
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

	// Queue status seen by both sides
	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

	// Back part sequencer
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DIV  = 2'b10
	} back_state_t;

endpackage

>>> sv/mmcs_front.sv
module mmcs_front import mmcs_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [SAMPLE_FIELD_W-1:0] s_axis_tdata,   // [15:0] sample
	input  logic                      s_axis_tlast,   // frame_end
	input  logic                      s_axis_tuser,   // action
	input  q_stat_t                   q_stat,
	output logic                      push,
	output logic [2*SAMPLE_BITS:0]    push_data       // {last, range, offset}
);

	logic [SAMPLE_BITS-1:0] running_low_q, running_high_q;
	logic [SAMPLE_BITS-1:0] latched_low_q, latched_high_q;
	logic [SAMPLE_BITS-1:0] v, lo_next, hi_next, v_clamp, offset, range;
	logic                   fire, meas, meas_last, zero_range;

	assign s_axis_tready = !q_stat.full;
	assign fire          = s_axis_tvalid && s_axis_tready;
	assign meas          = fire && !s_axis_tuser;
	assign meas_last     = meas && s_axis_tlast;
	assign push          = fire && s_axis_tuser;
	assign v             = s_axis_tdata[SAMPLE_BITS-1:0];

	always_comb begin
		lo_next = (v < running_low_q)  ? v : running_low_q;
		hi_next = (v > running_high_q) ? v : running_high_q;
	end

	// Clamp to the latched pair; a zero range maps to offset 0 over range 1
	always_comb begin
		zero_range = latched_high_q <= latched_low_q;
		v_clamp    = v;
		if (v < latched_low_q) begin
			v_clamp = latched_low_q;
		end
		if (v > latched_high_q) begin
			v_clamp = latched_high_q;
		end
		if (zero_range) begin
			offset = '0;
			range  = SAMPLE_BITS'(1);
		end else begin
			offset = v_clamp - latched_low_q;
			range  = latched_high_q - latched_low_q;
		end
	end

	assign push_data = {s_axis_tlast, range, offset};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_low_q  <= '1;
			running_high_q <= '0;
			latched_low_q  <= '0;
			latched_high_q <= '0;
		end else if (meas_last) begin
			latched_low_q  <= lo_next;
			latched_high_q <= hi_next;
			running_low_q  <= '1;
			running_high_q <= '0;
		end else if (meas) begin
			running_low_q  <= lo_next;
			running_high_q <= hi_next;
		end
	end

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full) else $error("push into full queue");
	a_latch_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		meas_last |=> latched_low_q <= latched_high_q)
		else $error("latched pair out of order");
	a_tracker_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		meas_last |=> (running_low_q == '1) && (running_high_q == '0))
		else $error("trackers not rearmed after pass");

endmodule

>>> sv/mmcs_queue.sv
module mmcs_queue import mmcs_pkg::*; #(
	parameter int unsigned W = 33
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output q_stat_t      q_stat
);

	logic [W-1:0]    ents_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   count_q;

	assign q_stat.not_empty = count_q != '0;
	assign q_stat.full      = count_q == (Q_AW+1)'(Q_DEPTH);
	assign pop_data         = ents_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ents_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (Q_AW+1)'(Q_DEPTH)) else $error("queue count overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.not_empty) else $error("pop from empty queue");

endmodule

>>> sv/mmcs_back.sv
module mmcs_back import mmcs_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  q_stat_t                q_stat,
	input  logic [2*SAMPLE_BITS:0] pop_data,      // {last, range, offset}
	output logic                   pop,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [GRAY_BITS-1:0]   m_axis_tdata,  // [7:0] gray
	output logic                   m_axis_tlast   // frame_done
);

	localparam int unsigned NW = SAMPLE_BITS + 9;

	back_state_t            state_q;
	logic [NW-1:0]          rem_q, den_sh_q, num;
	logic [GRAY_BITS-1:0]   quo_q, gray_q;
	logic [STEP_W-1:0]      cnt_q;
	logic                   done_q, last_q, out_valid_q, out_last_q;
	logic [SAMPLE_BITS-1:0] offset, range;
	logic                   ge, emit;

	assign offset = pop_data[SAMPLE_BITS-1:0];
	assign range  = pop_data[2*SAMPLE_BITS-1:SAMPLE_BITS];

	// 510*offset + range, the doubled and rounded numerator
	assign num  = {offset, 9'b0} - NW'({offset, 1'b0}) + NW'(range);
	assign ge   = rem_q >= den_sh_q;
	assign pop  = (state_q == ST_IDLE) && q_stat.not_empty;
	assign emit = (state_q == ST_DIV) && done_q && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = gray_q;
	assign m_axis_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			rem_q    <= num;
			den_sh_q <= {1'b0, range, {GRAY_BITS{1'b0}}};
			last_q   <= pop_data[2*SAMPLE_BITS];
		end else if ((state_q == ST_DIV) && !done_q) begin
			if (ge) begin
				rem_q <= rem_q - den_sh_q;
			end
			den_sh_q <= den_sh_q >> 1;
			quo_q    <= {quo_q[GRAY_BITS-2:0], ge};
		end
		if (emit) begin
			gray_q     <= quo_q;
			out_last_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
						done_q  <= 1'b0;
					end
				end
				ST_DIV: begin
					if (!done_q) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == STEP_W'(GRAY_BITS-1)) begin
							done_q <= 1'b1;
						end
					end else if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_pop_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_DIV) && !done_q) else $error("load did not start divide");
	a_emit_after_steps: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> cnt_q == '0) else $error("result before all quotient bits");

endmodule

>>> sv/minmax_contrast_stretch_top.sv
// Min-max contrast stretch, 16-bit samples to 8-bit gray.
// Input stream (s_axis_*): tdata carries the sample, tuser the action
// (0 = measure pass, 1 = map pass), tlast marks the last sample of a pass.
// Output stream (m_axis_*): tdata carries the gray value, tlast marks the
// result of the map pass's last sample. Measure beats give no output.
// Stream the frame once as measure beats: the running min/max is latched on
// the tlast beat. Then stream it again as map beats, each giving
// round((v-min)*255/(max-min)), clamped, and 0 for an empty range.
// Rate: measure beats are taken one per cycle while the four-entry queue has
// room. In the back part each map beat is loaded, resolved by eight
// restoring divider steps (one quotient bit each) and written to the output
// register; a new map beat is loaded only once the last one is written, so
// that divider sets the map rate.
// Reset clears the trackers (min all ones, max zero), the latched pair to
// zero, the queue and the output valid flag. When the receiver stalls the
// output register holds its beat, the divider finishes and waits, the queue
// fills, and then tready drops.
module minmax_contrast_stretch_top import mmcs_pkg::*; #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [SAMPLE_FIELD_W-1:0] s_axis_tdata,   // [15:0] sample
	input  logic                      s_axis_tlast,   // frame_end
	input  logic                      s_axis_tuser,   // action
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [GRAY_BITS-1:0]      m_axis_tdata,   // [7:0] gray
	output logic                      m_axis_tlast    // frame_done
);

	localparam int unsigned QW = 2*SAMPLE_BITS + 1;

	q_stat_t         q_stat;
	logic            push, pop;
	logic [QW-1:0]   push_data, pop_data;

	// Front: track min/max on measure beats, clamp and offset map beats
	mmcs_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.q_stat        (q_stat),
		.push          (push),
		.push_data     (push_data)
	);

	// Queue: map beats carry their own offset and range, so a new latch
	// in the front never disturbs beats already waiting here
	mmcs_queue #(.W(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	// Back: bit-serial rounded divide and output register
	mmcs_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.pop_data      (pop_data),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
